// ===== src/ams_pkg.sv =====
package ams_pkg;

   localparam int FLOOR_TILES   = 16;
   localparam int PROGRAM_DEPTH = 256;
   localparam int VALUE_BITS    = 16;

   localparam int OPERAND_BITS  = 8;
   localparam int WORD_BITS     = 16;
   localparam int ADDR_BITS     = 9;
   localparam int PC_BITS       = $clog2(PROGRAM_DEPTH + 1);
   localparam int TILE_IDX_BITS = (FLOOR_TILES > 1) ? $clog2(FLOOR_TILES) : 1;
   localparam int TILE_CNT_BITS = $clog2(FLOOR_TILES + 1);
   localparam int TCMP_BITS     = (TILE_CNT_BITS > OPERAND_BITS) ? TILE_CNT_BITS
                                                                 : OPERAND_BITS + 1;
   localparam int JCMP_BITS     = (PC_BITS > OPERAND_BITS) ? PC_BITS : OPERAND_BITS;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;
   localparam int PLEN_BITS      = 9;
   localparam int TUSE_BITS      = 5;
   localparam int OPEN_BITS      = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROGRAM_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TILES_IN_USE   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPCODE_ENABLE  = 2'd2;

   typedef logic [VALUE_BITS-1:0]       value_type;
   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [PC_BITS-1:0]          pc_type;

   typedef enum logic [2:0] {
      OP_INBOX      = 3'd0,
      OP_OUTBOX     = 3'd1,
      OP_COPYFROM   = 3'd2,
      OP_COPYTO     = 3'd3,
      OP_ADD        = 3'd4,
      OP_SUB        = 3'd5,
      OP_JUMP       = 3'd6,
      OP_JUMPIFZERO = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      RUN_RUNNING = 2'd0,
      RUN_HALTED  = 2'd1,
      RUN_ERROR   = 2'd2
   } run_type;

   typedef struct packed {
      op_type                  op;
      logic [OPERAND_BITS-1:0] operand;
      logic                    inbox_empty;
      word_type                inbox_value;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] next_address;
      logic                 inbox_taken;
      logic                 outbox_valid;
      word_type             outbox_value;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      pc_type                   prog_len;
      logic [TILE_CNT_BITS-1:0] tile_count;
      logic [OPEN_BITS-1:0]     opcode_enable;
   } cfg_type;

   typedef struct packed {
      req_type req;
      logic    op_enabled;
      logic    tile_ok;
      logic    target_ok;
   } cmd_type;

endpackage

// ===== src/ams_front.sv =====
module ams_front (
   input  logic             clock,
   input  logic             reset,
   input  ams_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  ams_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output ams_pkg::cmd_type cmd_data
);

   ams_pkg::cmd_type cmd_new;
   ams_pkg::cmd_type queue_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   // classify the request against the current configuration
   always_comb begin
      cmd_new.req        = req_data;
      cmd_new.op_enabled = cfg.opcode_enable[req_data.op];
      cmd_new.tile_ok    = ams_pkg::TCMP_BITS'(req_data.operand) <
                           ams_pkg::TCMP_BITS'(cfg.tile_count);
      cmd_new.target_ok  = (req_data.operand != '0) &&
                           (ams_pkg::JCMP_BITS'(req_data.operand) <
                            ams_pkg::JCMP_BITS'(cfg.prog_len));
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== src/ams_back.sv =====
module ams_back (
   input  logic             clock,
   input  logic             reset,
   input  ams_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ams_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ams_pkg::rsp_type rsp_data
);

   ams_pkg::value_type tile_ff [ams_pkg::FLOOR_TILES];
   logic [ams_pkg::FLOOR_TILES-1:0] filled_ff, filled_in;

   ams_pkg::value_type held_ff, held_in;
   logic               holding_ff, holding_in;
   ams_pkg::pc_type    pc_ff, pc_in;
   ams_pkg::run_type   run_ff, run_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ams_pkg::rsp_type   rsp_ff, rsp_in;

   logic                              take;
   logic [ams_pkg::TILE_IDX_BITS-1:0] idx;
   ams_pkg::value_type                tile_rd;
   logic                              readable;
   logic                              tile_we;
   logic                              err, taken, outv;
   ams_pkg::pc_type                   next;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign idx       = ams_pkg::TILE_IDX_BITS'(cmd_data.req.operand);
   assign tile_rd   = tile_ff[idx];
   assign readable  = cmd_data.tile_ok && filled_ff[idx];

   always_comb begin
      held_in    = held_ff;
      holding_in = holding_ff;
      pc_in      = pc_ff;
      run_in     = run_ff;
      filled_in  = filled_ff;
      tile_we    = 1'b0;
      err        = 1'b0;
      taken      = 1'b0;
      outv       = 1'b0;
      next       = pc_ff + 1'b1;
      if (take) begin
         if (run_in == ams_pkg::RUN_RUNNING && pc_ff >= cfg.prog_len) begin
            run_in = ams_pkg::RUN_HALTED;
         end
         if (run_in == ams_pkg::RUN_RUNNING) begin
            if (!cmd_data.op_enabled) begin
               err = 1'b1;
            end else begin
               unique case (cmd_data.req.op)
                  ams_pkg::OP_INBOX: begin
                     if (cmd_data.req.inbox_empty) begin
                        run_in = ams_pkg::RUN_HALTED;
                        next   = pc_ff;
                     end else begin
                        held_in    = ams_pkg::value_type'(cmd_data.req.inbox_value);
                        holding_in = 1'b1;
                        taken      = 1'b1;
                     end
                  end
                  ams_pkg::OP_OUTBOX: begin
                     if (!holding_ff) begin
                        err = 1'b1;
                     end else begin
                        outv       = 1'b1;
                        holding_in = 1'b0;
                     end
                  end
                  ams_pkg::OP_COPYFROM: begin
                     if (!readable) begin
                        err = 1'b1;
                     end else begin
                        held_in    = tile_rd;
                        holding_in = 1'b1;
                     end
                  end
                  ams_pkg::OP_COPYTO: begin
                     if (!holding_ff || !cmd_data.tile_ok) begin
                        err = 1'b1;
                     end else begin
                        tile_we        = 1'b1;
                        filled_in[idx] = 1'b1;
                     end
                  end
                  ams_pkg::OP_ADD, ams_pkg::OP_SUB: begin
                     if (!holding_ff || !readable) begin
                        err = 1'b1;
                     end else if (cmd_data.req.op == ams_pkg::OP_ADD) begin
                        held_in = held_ff + tile_rd;
                     end else begin
                        held_in = held_ff - tile_rd;
                     end
                  end
                  ams_pkg::OP_JUMP: begin
                     if (!cmd_data.target_ok) begin
                        err = 1'b1;
                     end else begin
                        next = ams_pkg::PC_BITS'(cmd_data.req.operand) - 1'b1;
                     end
                  end
                  ams_pkg::OP_JUMPIFZERO: begin
                     if (!holding_ff || !cmd_data.target_ok) begin
                        err = 1'b1;
                     end else if (held_ff == '0) begin
                        next = ams_pkg::PC_BITS'(cmd_data.req.operand) - 1'b1;
                     end
                  end
                  default: begin
                     err = 1'b1;
                  end
               endcase
            end
            if (err) begin
               run_in     = ams_pkg::RUN_ERROR;
               held_in    = held_ff;
               holding_in = holding_ff;
               filled_in  = filled_ff;
               tile_we    = 1'b0;
               taken      = 1'b0;
               outv       = 1'b0;
            end else begin
               pc_in = next;
               if (run_in == ams_pkg::RUN_RUNNING && next >= cfg.prog_len) begin
                  run_in = ams_pkg::RUN_HALTED;
               end
            end
         end
      end

      rsp_in.next_address = ams_pkg::ADDR_BITS'(pc_in);
      rsp_in.inbox_taken  = taken;
      rsp_in.outbox_valid = outv;
      rsp_in.outbox_value = outv ? ams_pkg::word_type'(signed'(held_ff)) : '0;
      rsp_in.status       = run_in;

      rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         holding_ff   <= 1'b0;
         pc_ff        <= '0;
         run_ff       <= ams_pkg::RUN_RUNNING;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         holding_ff   <= holding_in;
         pc_ff        <= pc_in;
         run_ff       <= run_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tile_we) begin
         tile_ff[idx] <= held_ff;
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/accumulator_machine_step.sv =====
// Accumulator machine, one instruction per request. Each request carries the
// instruction fetched at the last reported next_address together with the
// inbox head; the response gives the next address, inbox and outbox activity
// and the run status. Requests enter a two-entry queue after classification
// and the execute stage retires one per cycle into an output register while
// the response is not held, so the sustained rate is one request per clock
// without back-pressure; it is set by the execute loop over the held value,
// the program counter and the sixteen-tile store. The tile fill flags are
// cleared at reset; the tile values are not. After a halt or an error the
// machine stays frozen until reset. Configuration writes are accepted at any
// time but take effect correctly only while no request is in flight.
module accumulator_machine_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ams_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ams_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ams_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ams_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   logic [ams_pkg::PLEN_BITS-1:0] plen_ff, plen_in;
   logic [ams_pkg::TUSE_BITS-1:0] tuse_ff, tuse_in;
   logic [ams_pkg::OPEN_BITS-1:0] open_ff, open_in;
   ams_pkg::cfg_type              cfg;
   logic                          cmd_valid, cmd_ready;
   ams_pkg::cmd_type              cmd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      plen_in = plen_ff;
      tuse_in = tuse_ff;
      open_in = open_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ams_pkg::CSR_PROGRAM_LENGTH: plen_in = ams_pkg::PLEN_BITS'(csr_data);
            ams_pkg::CSR_TILES_IN_USE:   tuse_in = ams_pkg::TUSE_BITS'(csr_data);
            ams_pkg::CSR_OPCODE_ENABLE:  open_in = ams_pkg::OPEN_BITS'(csr_data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= ams_pkg::PLEN_BITS'(1);
         tuse_ff <= '0;
         open_ff <= '1;
      end else begin
         plen_ff <= plen_in;
         tuse_ff <= tuse_in;
         open_ff <= open_in;
      end
   end

   // saturate to the implemented program and floor sizes
   always_comb begin
      if (32'(plen_ff) > ams_pkg::PROGRAM_DEPTH) begin
         cfg.prog_len = ams_pkg::PC_BITS'(ams_pkg::PROGRAM_DEPTH);
      end else begin
         cfg.prog_len = ams_pkg::PC_BITS'(plen_ff);
      end
      if (32'(tuse_ff) > ams_pkg::FLOOR_TILES) begin
         cfg.tile_count = ams_pkg::TILE_CNT_BITS'(ams_pkg::FLOOR_TILES);
      end else begin
         cfg.tile_count = ams_pkg::TILE_CNT_BITS'(tuse_ff);
      end
      cfg.opcode_enable = open_ff;
   end

   ams_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   ams_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/accumulator_machine_step_test.sv =====
module accumulator_machine_step_test;

   localparam int HOLD_CYCLES   = 80;
   localparam int TAIL_CYCLES   = 8;
   localparam int PHASE_ITEMS   = 95;
   localparam int FROZEN_ITEMS  = 12;
   localparam int ENABLE_FLOOR  = (1 << ams_pkg::OP_INBOX) | (1 << ams_pkg::OP_JUMP);

   typedef enum int {
      END_INBOX_EMPTY,
      END_OF_PROGRAM,
      END_PAST_LENGTH,
      END_OP_DISABLED,
      END_NOTHING_HELD,
      END_BAD_TILE,
      END_BAD_TARGET
   } end_kind_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   ams_pkg::req_type                   req_data;
   logic                               rsp_valid;
   logic                               rsp_ready;
   ams_pkg::rsp_type                   rsp_data;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [ams_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [ams_pkg::CSR_DATA_BITS-1:0]  csr_data;

   // machine model
   logic [ams_pkg::PLEN_BITS-1:0] plen_model    = 9'd1;
   logic [ams_pkg::TUSE_BITS-1:0] tiles_model   = 5'd0;
   logic [ams_pkg::OPEN_BITS-1:0] enable_model  = 8'hFF;
   ams_pkg::word_type             held_model    = '0;
   bit                            holding_model = 1'b0;
   logic [ams_pkg::ADDR_BITS-1:0] pc_model      = '0;
   ams_pkg::word_type             tile_value_model [ams_pkg::FLOOR_TILES];
   bit                            tile_filled_model [ams_pkg::FLOOR_TILES];
   ams_pkg::run_type              run_model     = ams_pkg::RUN_RUNNING;

   ams_pkg::rsp_type expected_responses [$];
   int               fail_count        = 0;
   int               requests_sent     = 0;
   int               responses_checked = 0;
   int               csr_writes        = 0;
   bit               gaps_on           = 1'b1;
   bit               hold_request      = 1'b0;
   end_kind_type     end_kind;

   accumulator_machine_step DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAIL accumulator_machine_step");
      $finish;
   end

   function automatic int effective_length();
      return (plen_model > ams_pkg::PROGRAM_DEPTH) ? ams_pkg::PROGRAM_DEPTH
                                                   : int'(plen_model);
   endfunction

   function automatic int effective_tiles();
      return (tiles_model > ams_pkg::FLOOR_TILES) ? ams_pkg::FLOOR_TILES
                                                  : int'(tiles_model);
   endfunction

   function automatic bit tile_readable(int x);
      return x < effective_tiles() && tile_filled_model[x];
   endfunction

   function automatic ams_pkg::rsp_type machine_step_predict(ams_pkg::req_type r);
      ams_pkg::rsp_type  p;
      int                len;
      int                tcnt;
      int                next;
      int                x;
      bit                err;
      bit                taken;
      bit                outv;
      ams_pkg::word_type outval;
      len    = effective_length();
      tcnt   = effective_tiles();
      x      = int'(r.operand);
      next   = int'(pc_model) + 1;
      err    = 1'b0;
      taken  = 1'b0;
      outv   = 1'b0;
      outval = '0;
      if (run_model == ams_pkg::RUN_RUNNING && int'(pc_model) >= len) begin
         run_model = ams_pkg::RUN_HALTED;
      end
      if (run_model == ams_pkg::RUN_RUNNING) begin
         if (!enable_model[r.op]) begin
            err = 1'b1;
         end else begin
            case (r.op)
               ams_pkg::OP_INBOX: begin
                  if (r.inbox_empty) begin
                     run_model = ams_pkg::RUN_HALTED;
                     next = int'(pc_model);
                  end else begin
                     held_model = r.inbox_value;
                     holding_model = 1'b1;
                     taken = 1'b1;
                  end
               end
               ams_pkg::OP_OUTBOX: begin
                  if (!holding_model) err = 1'b1;
                  else begin
                     outv = 1'b1;
                     outval = held_model;
                     holding_model = 1'b0;
                  end
               end
               ams_pkg::OP_COPYFROM: begin
                  if (!tile_readable(x)) err = 1'b1;
                  else begin
                     held_model = tile_value_model[x];
                     holding_model = 1'b1;
                  end
               end
               ams_pkg::OP_COPYTO: begin
                  if (!holding_model || x >= tcnt) err = 1'b1;
                  else begin
                     tile_value_model[x] = held_model;
                     tile_filled_model[x] = 1'b1;
                  end
               end
               ams_pkg::OP_ADD, ams_pkg::OP_SUB: begin
                  if (!holding_model || !tile_readable(x)) err = 1'b1;
                  else if (r.op == ams_pkg::OP_ADD) begin
                     held_model = held_model + tile_value_model[x];
                  end else begin
                     held_model = held_model - tile_value_model[x];
                  end
               end
               ams_pkg::OP_JUMP: begin
                  if (x < 1 || x >= len) err = 1'b1;
                  else next = x - 1;
               end
               default: begin
                  if (!holding_model || x < 1 || x >= len) err = 1'b1;
                  else if (held_model == 0) next = x - 1;
               end
            endcase
         end
         if (err) begin
            run_model = ams_pkg::RUN_ERROR;
         end else begin
            pc_model = ams_pkg::ADDR_BITS'(next);
            if (run_model == ams_pkg::RUN_RUNNING && next >= len) begin
               run_model = ams_pkg::RUN_HALTED;
            end
         end
      end
      p.next_address = pc_model;
      p.inbox_taken  = taken;
      p.outbox_valid = outv;
      p.outbox_value = outval;
      p.status       = run_model;
      return p;
   endfunction

   function automatic ams_pkg::word_type pick_value();
      case ($urandom_range(0, 5))
         0: return 16'sh0000;
         1: return 16'sh7FFF;
         2: return 16'sh8000;
         3: return 16'shFFFF;
         default: return ams_pkg::word_type'($urandom_range(0, 65535));
      endcase
   endfunction

   // an instruction that keeps the machine running, with random content
   function automatic ams_pkg::req_type plan_running_item();
      ams_pkg::req_type r;
      int               len;
      int               tcnt;
      int               target;
      int               readable [$];
      bit               ok;
      bit               fall_ok;
      len  = effective_length();
      tcnt = effective_tiles();
      for (int i = 0; i < tcnt; i++) if (tile_filled_model[i]) readable = {readable, i};
      fall_ok       = (int'(pc_model) + 1) < len;
      r.operand     = ams_pkg::OPERAND_BITS'($urandom_range(0, 255));
      r.inbox_empty = 1'($urandom_range(0, 1));
      r.inbox_value = pick_value();
      target        = $urandom_range(1, len - 1);
      ok            = 1'b0;
      for (int tries = 0; tries < 64 && !ok; tries++) begin
         r.op = ams_pkg::op_type'($urandom_range(0, 7));
         if (enable_model[r.op]) begin
            case (r.op)
               ams_pkg::OP_INBOX: begin
                  ok = fall_ok;
                  r.inbox_empty = 1'b0;
               end
               ams_pkg::OP_OUTBOX: ok = fall_ok && holding_model;
               ams_pkg::OP_COPYFROM: begin
                  if (fall_ok && readable.size() > 0) begin
                     ok = 1'b1;
                     r.operand = ams_pkg::OPERAND_BITS'(
                        readable[$urandom_range(0, readable.size() - 1)]);
                  end
               end
               ams_pkg::OP_COPYTO: begin
                  if (fall_ok && holding_model && tcnt > 0) begin
                     ok = 1'b1;
                     r.operand = ams_pkg::OPERAND_BITS'($urandom_range(0, tcnt - 1));
                  end
               end
               ams_pkg::OP_ADD, ams_pkg::OP_SUB: begin
                  if (fall_ok && holding_model && readable.size() > 0) begin
                     ok = 1'b1;
                     r.operand = ams_pkg::OPERAND_BITS'(
                        readable[$urandom_range(0, readable.size() - 1)]);
                  end
               end
               ams_pkg::OP_JUMP: begin
                  ok = 1'b1;
                  r.operand = ams_pkg::OPERAND_BITS'(target);
               end
               default: begin
                  if (holding_model && (fall_ok || held_model == 0)) begin
                     ok = 1'b1;
                     r.operand = ams_pkg::OPERAND_BITS'(target);
                  end
               end
            endcase
         end
      end
      if (!ok) begin
         r.op = ams_pkg::OP_JUMP;
         r.operand = ams_pkg::OPERAND_BITS'(target);
      end
      return r;
   endfunction

   task automatic send_request(input ams_pkg::req_type r);
      int               gap;
      ams_pkg::rsp_type want;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = machine_step_predict(r);
      expected_responses = {expected_responses, want};
      requests_sent++;
   endtask

   task automatic send_instruction(input ams_pkg::op_type op, input int operand,
                                   input bit empty, input ams_pkg::word_type value);
      ams_pkg::req_type r;
      r.op          = op;
      r.operand     = ams_pkg::OPERAND_BITS'(operand);
      r.inbox_empty = empty;
      r.inbox_value = value;
      send_request(r);
   endtask

   task automatic send_noise();
      ams_pkg::req_type r;
      r.op          = ams_pkg::op_type'($urandom_range(0, 7));
      r.operand     = ams_pkg::OPERAND_BITS'($urandom_range(0, 255));
      r.inbox_empty = 1'($urandom_range(0, 1));
      r.inbox_value = pick_value();
      send_request(r);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input int plen, input int tiles, input int enable_mask);
      logic [ams_pkg::CSR_INDEX_BITS-1:0] idx [3];
      logic [ams_pkg::CSR_DATA_BITS-1:0]  val [3];
      idx[0] = ams_pkg::CSR_PROGRAM_LENGTH;
      idx[1] = ams_pkg::CSR_TILES_IN_USE;
      idx[2] = ams_pkg::CSR_OPCODE_ENABLE;
      val[0] = ams_pkg::CSR_DATA_BITS'(plen);
      val[1] = ams_pkg::CSR_DATA_BITS'(tiles);
      val[2] = ams_pkg::CSR_DATA_BITS'(enable_mask);
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx[i])
            ams_pkg::CSR_PROGRAM_LENGTH: plen_model  = val[i][ams_pkg::PLEN_BITS-1:0];
            ams_pkg::CSR_TILES_IN_USE:   tiles_model = val[i][ams_pkg::TUSE_BITS-1:0];
            default:                     enable_model = val[i][ams_pkg::OPEN_BITS-1:0];
         endcase
         csr_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   // jump back to the first instruction so that a shorter program stays valid
   task automatic rewind_and_drain();
      send_instruction(ams_pkg::OP_JUMP, 1, 1'($urandom_range(0, 1)), pick_value());
      drain_responses();
   endtask

   task automatic check_response(input ams_pkg::rsp_type got);
      ams_pkg::rsp_type want;
      if (expected_responses.size() == 0) begin
         $error("response with no request outstanding: %p", got);
         fail_count++;
      end else begin
         want = expected_responses.pop_front();
         responses_checked++;
         if (got.next_address !== want.next_address) begin
            $error("next_address expected %0d actual %0d", want.next_address, got.next_address);
            fail_count++;
         end
         if (got.inbox_taken !== want.inbox_taken) begin
            $error("inbox_taken expected %0d actual %0d", want.inbox_taken, got.inbox_taken);
            fail_count++;
         end
         if (got.outbox_valid !== want.outbox_valid) begin
            $error("outbox_valid expected %0d actual %0d", want.outbox_valid, got.outbox_valid);
            fail_count++;
         end
         if (got.outbox_value !== want.outbox_value) begin
            $error("outbox_value expected %0d actual %0d", want.outbox_value, got.outbox_value);
            fail_count++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            fail_count++;
         end
      end
   endtask

   initial begin : response_sink
      int wait_cycles;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         wait_cycles = gaps_on ? $urandom_range(0, 3) : 0;
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         check_response(rsp_data);
      end
   end

   task automatic test_directed();
      set_config(ams_pkg::PROGRAM_DEPTH, ams_pkg::FLOOR_TILES, 255);
      send_instruction(ams_pkg::OP_INBOX, 0, 1'b0, 16'sh7FFF);
      send_instruction(ams_pkg::OP_COPYTO, 0, 1'b0, 16'sh0000);
      send_instruction(ams_pkg::OP_INBOX, 255, 1'b0, 16'sh8000);
      send_instruction(ams_pkg::OP_COPYTO, ams_pkg::FLOOR_TILES - 1, 1'b1, 16'shFFFF);
      send_instruction(ams_pkg::OP_ADD, 0, 1'b0, 16'sh1234);
      send_instruction(ams_pkg::OP_SUB, ams_pkg::FLOOR_TILES - 1, 1'b1, 16'sh8000);
      send_instruction(ams_pkg::OP_OUTBOX, 170, 1'b1, 16'sh7FFF);
      send_instruction(ams_pkg::OP_COPYFROM, ams_pkg::FLOOR_TILES - 1, 1'b0, 16'sh0001);
      send_instruction(ams_pkg::OP_JUMPIFZERO, 200, 1'b0, 16'sh0000);
      send_instruction(ams_pkg::OP_ADD, ams_pkg::FLOOR_TILES - 1, 1'b1, 16'shFFFF);
      // held value wrapped to zero, so this one is taken
      send_instruction(ams_pkg::OP_JUMPIFZERO, 255, 1'b0, 16'sh5555);
      send_instruction(ams_pkg::OP_COPYTO, 7, 1'b0, 16'shAAAA);
      send_instruction(ams_pkg::OP_JUMP, 255, 1'b1, 16'sh0000);
      send_instruction(ams_pkg::OP_OUTBOX, 85, 1'b0, 16'sh8000);
      rewind_and_drain();
   endtask

   task automatic test_random_programs();
      int plen;
      int tiles;
      int enable_mask;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               plen = ams_pkg::PROGRAM_DEPTH;
               tiles = ams_pkg::FLOOR_TILES;
               enable_mask = 255;
            end
            1: begin plen = 2; tiles = 0; enable_mask = ENABLE_FLOOR; end
            2: begin plen = 511; tiles = 31; enable_mask = 255; end
            default: begin
               plen        = $urandom_range(2, ams_pkg::PROGRAM_DEPTH);
               tiles       = $urandom_range(0, ams_pkg::FLOOR_TILES);
               enable_mask = $urandom_range(0, 255) | ENABLE_FLOOR;
            end
         endcase
         gaps_on = (phase != 3);
         set_config(plen, tiles, enable_mask);
         for (int i = 0; i < PHASE_ITEMS; i++) send_request(plan_running_item());
         rewind_and_drain();
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      set_config(ams_pkg::PROGRAM_DEPTH, ams_pkg::FLOOR_TILES, 255);
      gaps_on = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++) send_request(plan_running_item());
      rewind_and_drain();
      gaps_on = 1'b1;
   endtask

   task automatic test_terminal();
      int len;
      end_kind = end_kind_type'($urandom_range(0, 6));
      set_config(ams_pkg::PROGRAM_DEPTH, ams_pkg::FLOOR_TILES, 255);
      case (end_kind)
         END_INBOX_EMPTY: begin
            send_instruction(ams_pkg::OP_INBOX, $urandom_range(0, 255), 1'b1, pick_value());
         end
         END_OF_PROGRAM: begin
            set_config($urandom_range(2, 24), ams_pkg::FLOOR_TILES, 255);
            while (run_model == ams_pkg::RUN_RUNNING)
               send_instruction(ams_pkg::OP_INBOX, $urandom_range(0, 255), 1'b0,
                                pick_value());
         end
         END_PAST_LENGTH: begin
            repeat (3)
               send_instruction(ams_pkg::OP_INBOX, $urandom_range(0, 255), 1'b0,
                                pick_value());
            drain_responses();
            set_config($urandom_range(0, 3), ams_pkg::FLOOR_TILES, 255);
            send_noise();
         end
         END_OP_DISABLED: begin
            set_config(ams_pkg::PROGRAM_DEPTH, ams_pkg::FLOOR_TILES, 0);
            send_noise();
         end
         END_NOTHING_HELD: begin
            if (holding_model) send_instruction(ams_pkg::OP_OUTBOX, 0, 1'b0, pick_value());
            case ($urandom_range(0, 4))
               0: send_instruction(ams_pkg::OP_OUTBOX, $urandom_range(0, 255), 1'b0,
                                   pick_value());
               1: send_instruction(ams_pkg::OP_COPYTO, $urandom_range(0, 15), 1'b0,
                                   pick_value());
               2: send_instruction(ams_pkg::OP_ADD, $urandom_range(0, 15), 1'b0,
                                   pick_value());
               3: send_instruction(ams_pkg::OP_SUB, $urandom_range(0, 15), 1'b0,
                                   pick_value());
               default: send_instruction(ams_pkg::OP_JUMPIFZERO, 1, 1'b0, pick_value());
            endcase
         end
         END_BAD_TILE: begin
            send_instruction(ams_pkg::op_type'($urandom_range(ams_pkg::OP_COPYFROM,
                                                              ams_pkg::OP_SUB)),
                             $urandom_range(ams_pkg::FLOOR_TILES, 255),
                             1'($urandom_range(0, 1)), pick_value());
         end
         default: begin
            set_config($urandom_range(2, 200), ams_pkg::FLOOR_TILES, 255);
            len = effective_length();
            send_instruction(ams_pkg::OP_JUMP,
                             $urandom_range(0, 1) ? 0 : $urandom_range(len, 255),
                             1'($urandom_range(0, 1)), pick_value());
         end
      endcase
      // machine is frozen from here on
      for (int i = 0; i < FROZEN_ITEMS; i++) send_noise();
      drain_responses();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      for (int i = 0; i < ams_pkg::FLOOR_TILES; i++) begin
         tile_value_model[i]  = '0;
         tile_filled_model[i] = 1'b0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_programs();
      test_backpressure();
      test_terminal();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d requests, %0d responses checked, %0d register writes",
               requests_sent, responses_checked, csr_writes);
      $display("machine stopped by %s with status %0d", end_kind.name(), run_model);
      if (fail_count == 0 && expected_responses.size() == 0) begin
         $display("PASS accumulator_machine_step");
      end else begin
         $display("FAIL accumulator_machine_step");
      end
      $finish;
   end

endmodule
